@@ design/msort_pkg.sv @@
// Shared types and constants for the merge sort engine.
// Used by the top level and its checker; depends on nothing.
package msort_pkg;

  // Width of one list element.
  localparam int unsigned WORD_W = 32;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK_L,
    S_BLK_R,
    S_CATCH_R,
    S_CATCH_L,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_EMIT_OUT
  } state_t;

endpackage

@@ design/msort_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; instantiated by the merge sort engine top level.
module msort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/merge_sort_engine.sv @@
// Merge sort engine top level: load, bottom-up merge sort and emit sequencer.
// Depends on msort_pkg and msort_ram.
//
// Usage:
// The input channel (in_valid/in_ready, value, is_last) takes one element per
// transfer into the element buffer, one transfer per cycle while loading.
// Elements beyond MAX_ELEMENTS are dropped and flag overflow for the run.
// The transfer marked is_last ends the list and starts the sort; in_ready
// stays low until the last sorted element has been delivered.
// Sorting runs ceil(log2(N)) passes over N elements, ping-ponging between
// two RAMs. The source RAM's read data is registered, so each merged block
// first fetches both heads, and every chosen head must be refetched before
// the next compare.
// The output channel (out_valid/out_ready, sorted_value, is_final, overflow)
// delivers the list in ascending order; each element is read, captured into
// the output register and transferred before the next is read. A stalled receiver
// simply holds the output register and the sequencer waits.
// Reset is synchronous and returns the block to an empty, idle state.
module merge_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [msort_pkg::WORD_W-1:0] value,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [msort_pkg::WORD_W-1:0] sorted_value,
  output logic                         is_final,
  output logic                         overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW = CW + 2;
  localparam int unsigned WW = msort_pkg::WORD_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  msort_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic          dropped;
  logic          sel;
  logic [CW-1:0] w;
  logic [CW-1:0] lo;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [AW-1:0] e;
  logic signed [WW-1:0] lh;
  logic signed [WW-1:0] rh;

  logic [AW-1:0] rd_addr;
  logic [WW-1:0] rd0, rd1, rdata;
  logic          we0, we1;
  logic [AW-1:0] waddr0;
  logic [WW-1:0] wdata0;

  logic          in_xfer, out_xfer, has_room, load_we;
  logic [CW-1:0] n_new;
  logic          take_left, blk_done, emit_last;
  logic [WW-1:0] merge_val;
  logic [SW-1:0] n_ext, lo_w, lo_2w, w2;
  logic [CW-1:0] mid_c, hi_c;

  // Handshake and load decode.
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign has_room = (count < MAX_CNT);
  assign load_we  = in_xfer && has_room;
  assign n_new    = has_room ? count + CW'(1) : count;

  // Block bounds for the current pass.
  assign n_ext = SW'(count);
  assign lo_w  = SW'(lo) + SW'(w);
  assign lo_2w = SW'(lo) + (SW'(w) << 1);
  assign w2    = SW'(w) << 1;
  assign mid_c = (lo_w  < n_ext) ? CW'(lo_w)  : count;
  assign hi_c  = (lo_2w < n_ext) ? CW'(lo_2w) : count;

  // Merge decision: the left head wins when the right block is exhausted or when strictly smaller.
  assign take_left = (i < mid) && (!(j < hi) || (lh < rh));
  assign merge_val = take_left ? lh : rh;
  assign blk_done  = ((k + CW'(1)) == hi);
  assign emit_last = ((CW'(e) + CW'(1)) == count);

  assign rdata = sel ? rd1 : rd0;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      msort_pkg::S_IDLE: begin
        if (in_xfer && is_last) begin
          state_next = (n_new > CW'(1)) ? msort_pkg::S_BLK_L : msort_pkg::S_EMIT_RD;
        end
      end
      msort_pkg::S_BLK_L:   state_next = msort_pkg::S_BLK_R;
      msort_pkg::S_BLK_R:   state_next = msort_pkg::S_CATCH_R;
      msort_pkg::S_CATCH_R: state_next = msort_pkg::S_MERGE;
      msort_pkg::S_CATCH_L: state_next = msort_pkg::S_MERGE;
      msort_pkg::S_MERGE: begin
        priority if (!blk_done) begin
          state_next = take_left ? msort_pkg::S_CATCH_L : msort_pkg::S_CATCH_R;
        end else if (lo_2w < n_ext) begin
          state_next = msort_pkg::S_BLK_L;
        end else if (w2 >= n_ext) begin
          state_next = msort_pkg::S_EMIT_RD;
        end else begin
          state_next = msort_pkg::S_BLK_L;
        end
      end
      msort_pkg::S_EMIT_RD:   state_next = msort_pkg::S_EMIT_WAIT;
      msort_pkg::S_EMIT_WAIT: state_next = msort_pkg::S_EMIT_OUT;
      msort_pkg::S_EMIT_OUT: begin
        if (out_ready) begin
          state_next = emit_last ? msort_pkg::S_IDLE : msort_pkg::S_EMIT_RD;
        end
      end
      default: state_next = msort_pkg::S_IDLE;
    endcase
  end

  // Control outputs: input ready and RAM read address.
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    unique case (state)
      msort_pkg::S_IDLE:    in_ready = 1'b1;
      msort_pkg::S_BLK_L:   rd_addr  = lo[AW-1:0];
      msort_pkg::S_BLK_R:   rd_addr  = j[AW-1:0];
      msort_pkg::S_MERGE:   rd_addr  = take_left ? AW'(i + CW'(1)) : AW'(j + CW'(1));
      msort_pkg::S_EMIT_RD: rd_addr  = e;
      default:              rd_addr  = '0;
    endcase
  end

  // RAM write ports: loading always fills RAM 0, a merge writes the other RAM.
  assign we0    = load_we || ((state == msort_pkg::S_MERGE) && sel);
  assign waddr0 = (state == msort_pkg::S_MERGE) ? k[AW-1:0] : count[AW-1:0];
  assign wdata0 = (state == msort_pkg::S_MERGE) ? merge_val : value;
  assign we1    = (state == msort_pkg::S_MERGE) && !sel;

  msort_ram #(.WIDTH(WW), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (rd_addr),
    .rdata (rd0)
  );

  msort_ram #(.WIDTH(WW), .DEPTH(MAX_ELEMENTS)) u_scratch (
    .clk   (clk),
    .we    (we1),
    .waddr (k[AW-1:0]),
    .wdata (merge_val),
    .raddr (rd_addr),
    .rdata (rd1)
  );

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msort_pkg::S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        msort_pkg::S_IDLE: begin
          if (in_xfer) begin
            count <= n_new;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            if (is_last) begin
              sel <= 1'b0;
              w   <= CW'(1);
              lo  <= '0;
              e   <= '0;
            end
          end
        end
        msort_pkg::S_BLK_L: begin
          i   <= lo;
          k   <= lo;
          j   <= mid_c;
          mid <= mid_c;
          hi  <= hi_c;
        end
        msort_pkg::S_BLK_R:   lh <= rdata;
        msort_pkg::S_CATCH_R: rh <= rdata;
        msort_pkg::S_CATCH_L: lh <= rdata;
        msort_pkg::S_MERGE: begin
          k <= k + CW'(1);
          if (take_left) begin
            i <= i + CW'(1);
          end else begin
            j <= j + CW'(1);
          end
          if (blk_done) begin
            if (lo_2w < n_ext) begin
              lo <= CW'(lo_2w);
            end else begin
              // Pass complete: the destination becomes the next source.
              sel <= !sel;
              lo  <= '0;
              w   <= CW'(w2);
              e   <= '0;
            end
          end
        end
        msort_pkg::S_EMIT_RD: begin
        end
        msort_pkg::S_EMIT_WAIT: begin
          sorted_value <= rdata;
          is_final     <= emit_last;
          overflow     <= dropped;
          out_valid    <= 1'b1;
        end
        msort_pkg::S_EMIT_OUT: begin
          if (out_xfer) begin
            out_valid <= 1'b0;
            e         <= e + AW'(1);
            if (emit_last) begin
              count   <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/msort_checker.sv @@
// Port-level checker for the merge sort engine, bound to the top level.
// Depends on msort_pkg for the element width.
module msort_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             is_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [msort_pkg::WORD_W-1:0]     sorted_value,
  input logic                             is_final,
  input logic                             overflow
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value)
      && $stable(is_final) && $stable(overflow))
    else $error("stalled result changed");

  // Loading and delivering never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // The last element of a list closes the input side.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> !in_ready)
    else $error("input still ready after the last element");

  // Delivering the final result reopens the input side at once.
  a_final_reopens: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_final |=> in_ready && !out_valid)
    else $error("block not idle after the final result");

endmodule

bind merge_sort_engine msort_checker u_msort_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .is_last      (is_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sorted_value (sorted_value),
  .is_final     (is_final),
  .overflow     (overflow)
);
